/* hw/rtl/fsd_pkg.sv */
// Shared types, phase and event codes, and header literals for the stream deframer.
package fsd_pkg;

    localparam logic [3:0] PH_WAIT_NL   = 4'd0;
    localparam logic [3:0] PH_FILE_LIT  = 4'd1;
    localparam logic [3:0] PH_NAME      = 4'd2;
    localparam logic [3:0] PH_SIZE_LIT  = 4'd3;
    localparam logic [3:0] PH_DIGITS    = 4'd4;
    localparam logic [3:0] PH_BLANK     = 4'd5;
    localparam logic [3:0] PH_PAYLOAD   = 4'd6;
    localparam logic [3:0] PH_ERROR     = 4'd7;
    localparam logic [3:0] PH_END_OK    = 4'd8;
    localparam logic [3:0] PH_END_TRUNC = 4'd9;

    localparam logic [2:0] EV_ABSORB  = 3'd0;
    localparam logic [2:0] EV_NAME    = 3'd1;
    localparam logic [2:0] EV_HEADER  = 3'd2;
    localparam logic [2:0] EV_PAYLOAD = 3'd3;
    localparam logic [2:0] EV_LAST    = 3'd4;
    localparam logic [2:0] EV_ERROR   = 3'd5;
    localparam logic [2:0] EV_END     = 3'd6;

    localparam logic [7:0] CHAR_NL  = 8'h0a;
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_D0  = 8'h30;
    localparam logic [7:0] CHAR_D9  = 8'h39;

    localparam logic [2:0] FILE_LIT_LEN = 3'd6;
    localparam logic [2:0] SIZE_LIT_LEN = 3'd7;

    localparam logic [0:0] REG_MODE = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } fsd_in_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  out_byte;
        logic [63:0] file_size;
        logic        truncated;
    } fsd_out_t;

    typedef struct packed {
        logic [3:0] phase;
        logic [2:0] lit_idx;
        logic       digit_seen;
    } fsd_ctrl_t;

    // "File: "
    function automatic logic [7:0] file_lit_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h46;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h6c;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h3a;
            3'd5:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "\nSize: "
    function automatic logic [7:0] size_lit_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h0a;
            3'd1:    c = 8'h53;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h7a;
            3'd4:    c = 8'h65;
            3'd5:    c = 8'h3a;
            3'd6:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/file_stream_deframer.sv */
// Top level of the file stream deframer: input stage, parser state, result register.
//
// Input channel (in_valid/in_ready/in_data) carries one raw byte or an end mark per
// transfer. Output channel (out_valid/out_ready/out_data) returns exactly one event
// per input transfer, in order. multi_file_mode is set over APB at address 0; the
// user must set it only while the block is idle, which the block does not enforce.
//
// Throughput: one byte per clock while the receiver takes each event. Each accepted
// byte is held in the input register, is parsed by combinational logic against the
// parser state, and lands in the result register, from which the event is presented.
// The longest path is the size digit step (acc*10 + digit, with the overflow check
// from its top bits) feeding the result and state registers.
//
// Reset clears the parser to wait for a leading newline and sets multi-file mode.
// When the receiver stalls, the result register holds, the input register fills,
// and in_ready drops until the result is taken.
module file_stream_deframer #(
    parameter int SIZE_BITS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fsd_pkg::fsd_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output fsd_pkg::fsd_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import fsd_pkg::*;

    logic                 multi_file_mode;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    fsd_in_t              s1_data_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    fsd_out_t             out_data_reg;

    fsd_ctrl_t            ctrl_reg;
    fsd_ctrl_t            ctrl_next;
    logic [SIZE_BITS-1:0] acc_reg;
    logic [SIZE_BITS-1:0] acc_next;
    logic [SIZE_BITS-1:0] remaining_reg;
    logic [SIZE_BITS-1:0] remaining_next;
    fsd_out_t             step_result;

    logic                 fire;
    logic                 in_xfer;

    fsd_apb_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .multi_file_mode (multi_file_mode)
    );

    fsd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .multi_file_mode (multi_file_mode),
        .item            (s1_data_reg),
        .ctrl            (ctrl_reg),
        .acc             (acc_reg),
        .remaining       (remaining_reg),
        .ctrl_next       (ctrl_next),
        .acc_next        (acc_next),
        .remaining_next  (remaining_next),
        .result          (step_result)
    );

    assign fire     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || fire;
    assign in_xfer  = in_valid && in_ready;

    assign s1_valid_next  = in_xfer || (s1_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= '{phase: PH_WAIT_NL, lit_idx: 3'd0, digit_seen: 1'b0};
            acc_reg       <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                ctrl_reg      <= ctrl_next;
                acc_reg       <= acc_next;
                remaining_reg <= remaining_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_data_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.phase == PH_ERROR |=> ctrl_reg.phase == PH_ERROR)
        else $error("error phase left");

    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        fire && step_result.event_kind == EV_ERROR |=> ctrl_reg.phase == PH_ERROR)
        else $error("error event without stop");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.phase == PH_PAYLOAD |-> remaining_reg != '0)
        else $error("payload phase with zero count");

    a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !fire |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("pending input transfer lost");

endmodule

/* hw/rtl/fsd_apb_regs.sv */
// APB configuration register block holding the multi-file mode bit.
module fsd_apb_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        multi_file_mode
);
    import fsd_pkg::*;

    logic mode_reg;
    logic mode_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MODE);

    always_comb
    begin
        mode_next = mode_reg;
        if (wr_en)
        begin
            mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // paddr[1:0] is the byte lane within the word
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_MODE && paddr[1:0] == 2'b00)
        begin
            prdata = {31'd0, mode_reg};
        end
    end

    assign multi_file_mode = mode_reg;
endmodule

/* hw/rtl/fsd_step.sv */
// Per-byte framing parser: next parse state and result for one transfer.
module fsd_step #(
    parameter int SIZE_BITS = 64
) (
    input  logic                     multi_file_mode,
    input  fsd_pkg::fsd_in_t         item,
    input  fsd_pkg::fsd_ctrl_t       ctrl,
    input  logic [SIZE_BITS-1:0]     acc,
    input  logic [SIZE_BITS-1:0]     remaining,
    output fsd_pkg::fsd_ctrl_t       ctrl_next,
    output logic [SIZE_BITS-1:0]     acc_next,
    output logic [SIZE_BITS-1:0]     remaining_next,
    output fsd_pkg::fsd_out_t        result
);
    import fsd_pkg::*;

    logic [7:0]           b;
    logic                 is_digit;
    logic [3:0]           digit;
    logic [SIZE_BITS+3:0] scaled;
    logic                 overflow;
    logic [SIZE_BITS-1:0] rem_dec;

    assign b        = item.data_byte;
    assign is_digit = (b >= CHAR_D0) && (b <= CHAR_D9);
    assign digit    = 4'(b - CHAR_D0);
    // acc*10 + d; anything above SIZE_BITS bits is an overflow
    assign scaled   = (SIZE_BITS+4)'({acc, 3'b000}) + (SIZE_BITS+4)'({acc, 1'b0})
                    + (SIZE_BITS+4)'(digit);
    assign overflow = |scaled[SIZE_BITS+3:SIZE_BITS];
    assign rem_dec  = remaining - SIZE_BITS'(1);

    always_comb
    begin
        ctrl_next         = ctrl;
        acc_next          = acc;
        remaining_next    = remaining;
        result.event_kind = EV_ABSORB;
        result.out_byte   = 8'd0;
        result.file_size  = 64'd0;
        result.truncated  = 1'b0;

        if (ctrl.phase == PH_END_OK)
        begin
            result.event_kind = EV_END;
        end
        else if (ctrl.phase == PH_END_TRUNC)
        begin
            result.event_kind = EV_END;
            result.truncated  = 1'b1;
        end
        else if (ctrl.phase > PH_PAYLOAD)
        begin
            ctrl_next.phase   = PH_ERROR;
            result.event_kind = EV_ERROR;
        end
        else if (!multi_file_mode)
        begin
            if (item.end_of_input)
            begin
                ctrl_next.phase   = PH_END_OK;
                result.event_kind = EV_END;
            end
            else
            begin
                result.event_kind = EV_PAYLOAD;
                result.out_byte   = b;
            end
        end
        else if (item.end_of_input)
        begin
            result.event_kind = EV_END;
            if (ctrl.phase == PH_WAIT_NL)
            begin
                ctrl_next.phase = PH_END_OK;
            end
            else
            begin
                ctrl_next.phase  = PH_END_TRUNC;
                result.truncated = 1'b1;
            end
        end
        else
        begin
            unique case (ctrl.phase)
                PH_WAIT_NL:
                begin
                    if (b == CHAR_NL)
                    begin
                        ctrl_next.phase   = PH_FILE_LIT;
                        ctrl_next.lit_idx = 3'd0;
                    end
                    else
                    begin
                        ctrl_next.phase   = PH_ERROR;
                        result.event_kind = EV_ERROR;
                    end
                end
                PH_FILE_LIT:
                begin
                    if (ctrl.lit_idx >= FILE_LIT_LEN || b != file_lit_char(ctrl.lit_idx))
                    begin
                        ctrl_next.phase   = PH_ERROR;
                        result.event_kind = EV_ERROR;
                    end
                    else if (ctrl.lit_idx == FILE_LIT_LEN - 3'd1)
                    begin
                        ctrl_next.lit_idx = 3'd0;
                        ctrl_next.phase   = PH_NAME;
                    end
                    else
                    begin
                        ctrl_next.lit_idx = ctrl.lit_idx + 3'd1;
                    end
                end
                PH_NAME:
                begin
                    if (b != CHAR_NUL)
                    begin
                        result.event_kind = EV_NAME;
                        result.out_byte   = b;
                    end
                    else
                    begin
                        ctrl_next.phase   = PH_SIZE_LIT;
                        ctrl_next.lit_idx = 3'd0;
                    end
                end
                PH_SIZE_LIT:
                begin
                    if (ctrl.lit_idx >= SIZE_LIT_LEN || b != size_lit_char(ctrl.lit_idx))
                    begin
                        ctrl_next.phase   = PH_ERROR;
                        result.event_kind = EV_ERROR;
                    end
                    else if (ctrl.lit_idx == SIZE_LIT_LEN - 3'd1)
                    begin
                        ctrl_next.lit_idx    = 3'd0;
                        ctrl_next.phase      = PH_DIGITS;
                        ctrl_next.digit_seen = 1'b0;
                        acc_next             = '0;
                    end
                    else
                    begin
                        ctrl_next.lit_idx = ctrl.lit_idx + 3'd1;
                    end
                end
                PH_DIGITS:
                begin
                    if (b == CHAR_NL)
                    begin
                        if (ctrl.digit_seen)
                        begin
                            ctrl_next.phase = PH_BLANK;
                        end
                        else
                        begin
                            ctrl_next.phase   = PH_ERROR;
                            result.event_kind = EV_ERROR;
                        end
                    end
                    else if (!is_digit || overflow)
                    begin
                        ctrl_next.phase   = PH_ERROR;
                        result.event_kind = EV_ERROR;
                    end
                    else
                    begin
                        acc_next             = scaled[SIZE_BITS-1:0];
                        ctrl_next.digit_seen = 1'b1;
                    end
                end
                PH_BLANK:
                begin
                    if (b == CHAR_NL)
                    begin
                        remaining_next    = acc;
                        ctrl_next.phase   = (acc == '0) ? PH_WAIT_NL : PH_PAYLOAD;
                        result.event_kind = EV_HEADER;
                        result.file_size  = 64'(acc);
                    end
                    else
                    begin
                        ctrl_next.phase   = PH_ERROR;
                        result.event_kind = EV_ERROR;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (remaining == '0)
                    begin
                        ctrl_next.phase   = PH_ERROR;
                        result.event_kind = EV_ERROR;
                    end
                    else
                    begin
                        remaining_next  = rem_dec;
                        result.out_byte = b;
                        if (rem_dec == '0)
                        begin
                            ctrl_next.phase   = PH_WAIT_NL;
                            result.event_kind = EV_LAST;
                        end
                        else
                        begin
                            result.event_kind = EV_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                    ctrl_next.phase   = PH_ERROR;
                    result.event_kind = EV_ERROR;
                end
            endcase
        end
    end
endmodule
